@@ sv/bdbp_pkg.sv @@
// Package: types and constants for the byte distribution bit predictor.
`timescale 1ns / 1ps
package bdbp_pkg;
   localparam int NUM_SYMBOLS_DEF = 256;
   localparam int PROB_BITS_DEF   = 16;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 64;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_PREDICT = 2'd1,
      OP_PERCEIVE = 2'd2,
      OP_UPDATE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_MASK0 = 2'd0,
      CSR_MASK1 = 2'd1,
      CSR_MASK2 = 2'd2,
      CSR_MASK3 = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  entry_index;
      logic [15:0] entry_probability;
      logic        coded_bit;
   } req_type;

   typedef struct packed {
      logic [15:0] bit_probability;
      logic [7:0]  best_byte;
      logic [7:0]  range_low;
      logic [7:0]  range_high;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN,
      ST_DIV,
      ST_SWEEP,
      ST_DONE
   } state_type;
endpackage

@@ sv/bdbp_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module bdbp_div #(
   parameter int NW = 40,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          go,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quo
);
   localparam int CW = $clog2(NW + 1);
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in, done_ff, done_in;
   logic [DW:0]   trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      trial = {rem_ff, quo_ff[NW-1]};
      if (go) begin
         quo_in = num;
         rem_in = '0;
         cnt_in = CW'(NW);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, den}) begin
            rem_in = DW'(trial - {1'b0, den});
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

@@ sv/byte_distribution_bit_predictor.sv @@
// Top level: byte distribution bit predictor with a memory-held probability table.
// Load and perceive pass through ST_DONE to the result strobe; update sweeps every entry first.
// Predict scans the range lo..hi, then runs the divider; the divide is skipped when the
// total is zero. Next item may start with the strobe.
// Reset (synchronous) starts a clearing pass that writes every entry to 1/256; busy
// stays high during it. Results cannot be stalled.
`timescale 1ns / 1ps
module byte_distribution_bit_predictor #(
   parameter int NUM_SYMBOLS = bdbp_pkg::NUM_SYMBOLS_DEF,
   parameter int PROB_BITS   = bdbp_pkg::PROB_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  bdbp_pkg::req_type                   req_item,
   output logic                                rsp_valid,
   output bdbp_pkg::rsp_type                   rsp_item,
   input  logic                                csr_we,
   input  logic [bdbp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bdbp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import bdbp_pkg::*;

   localparam int AW = $clog2(NUM_SYMBOLS);
   localparam int SW = PROB_BITS + AW + 1;
   localparam int NW = SW + PROB_BITS;
   localparam logic [AW:0] LAST = (AW+1)'(NUM_SYMBOLS - 1);

   logic [PROB_BITS-1:0] mem [NUM_SYMBOLS];
   logic [PROB_BITS-1:0] rd_ff;
   logic                 we;
   logic [AW-1:0]        wa, ra;
   logic [PROB_BITS-1:0] wd;

   logic [63:0] mask_ff [4];
   state_type   st_ff, st_in;
   logic [AW-1:0] lo_ff, lo_in, hi_ff, hi_in, best_ff, best_in;
   logic [AW:0]   ptr_ff, ptr_in;
   logic [AW:0]   cur_ff, cur_in;
   logic          vld_ff, vld_in;
   logic [SW-1:0] num_ff, num_in, den_ff, den_in;
   logic [PROB_BITS-1:0] max_ff, max_in;
   logic          rv_ff, rv_in;
   rsp_type       rsp_ff, rsp_in;
   logic          div_go, div_done;
   logic [NW-1:0] div_q;
   logic [AW-1:0] mid;
   logic [7:0]    sym8;
   logic          allowed;
   logic [15:0]   qsat;

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) mask_ff[k] <= '1;
      end else if (csr_we) begin
         mask_ff[csr_index] <= csr_wdata;
      end
   end

   bdbp_div #(.NW(NW), .DW(SW)) u_div (
      .clock(clock), .reset(reset), .go(div_go),
      .num({num_ff, {PROB_BITS{1'b0}}}), .den(den_ff),
      .done(div_done), .quo(div_q)
   );

   assign mid  = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign sym8 = 8'(cur_ff);
   assign allowed = mask_ff[sym8[7:6]][sym8[5:0]];
   assign busy = (st_ff != ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      if (div_q > NW'({16{1'b1}})) qsat = 16'hFFFF;
      else qsat = 16'(div_q);
   end

   always_comb begin
      st_in = st_ff; lo_in = lo_ff; hi_in = hi_ff;
      best_in = best_ff; ptr_in = ptr_ff; cur_in = cur_ff; vld_in = 1'b0;
      num_in = num_ff; den_in = den_ff; max_in = max_ff;
      rv_in = 1'b0; rsp_in = rsp_ff; div_go = 1'b0;
      we = 1'b0; wa = ptr_ff[AW-1:0]; wd = '0; ra = ptr_ff[AW-1:0];
      unique case (st_ff)
         ST_CLEAR: begin
            we = 1'b1;
            wd = PROB_BITS'(1) << (PROB_BITS - 8);
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == LAST) st_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               rsp_in = '0;
               unique case (op_type'(req_item.operation))
                  OP_LOAD: begin
                     if (32'(req_item.entry_index) < NUM_SYMBOLS) begin
                        we = 1'b1;
                        wa = AW'(req_item.entry_index);
                        wd = PROB_BITS'(req_item.entry_probability);
                     end
                     st_in = ST_DONE;
                  end
                  OP_PREDICT: begin
                     ptr_in = {1'b0, lo_ff};
                     ra = lo_ff;
                     num_in = '0; den_in = '0; max_in = '0;
                     best_in = lo_ff;
                     st_in = ST_SCAN;
                  end
                  OP_PERCEIVE: begin
                     if (hi_ff > lo_ff) begin
                        if (req_item.coded_bit) lo_in = mid + 1'b1;
                        else hi_in = mid;
                     end
                     st_in = ST_DONE;
                  end
                  OP_UPDATE: begin
                     lo_in = '0;
                     hi_in = AW'(NUM_SYMBOLS - 1);
                     ptr_in = '0;
                     st_in = ST_SWEEP;
                  end
                  default: st_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN: begin
            // ptr issues reads; cur tracks the entry whose data is in rd_ff
            if (vld_ff) begin
               den_in = den_ff + SW'(rd_ff);
               if (cur_ff[AW-1:0] > mid) num_in = num_ff + SW'(rd_ff);
               if (cur_ff[AW-1:0] == lo_ff || rd_ff > max_ff) begin
                  max_in = rd_ff;
                  best_in = cur_ff[AW-1:0];
               end
            end
            if (ptr_ff <= {1'b0, hi_ff}) begin
               ra = ptr_ff[AW-1:0];
               vld_in = 1'b1;
               cur_in = ptr_ff;
               ptr_in = ptr_ff + 1'b1;
            end else if (!vld_ff) begin
               st_in = ST_DIV;
               div_go = 1'b1;
            end
         end
         ST_DIV: begin
            if (den_ff == '0) begin
               rsp_in.bit_probability = (PROB_BITS > 16) ? 16'hFFFF :
                  16'(PROB_BITS'(1) << (PROB_BITS - 1));
               rsp_in.best_byte = 8'(best_ff);
               st_in = ST_DONE;
            end else if (div_done) begin
               if (div_q > NW'((NW'(1) << PROB_BITS) - 1'b1))
                  rsp_in.bit_probability = 16'(((NW'(1) << PROB_BITS) - 1'b1) >
                     NW'(16'hFFFF) ? NW'(16'hFFFF) : (NW'(1) << PROB_BITS) - 1'b1);
               else rsp_in.bit_probability = qsat;
               rsp_in.best_byte = 8'(best_ff);
               st_in = ST_DONE;
            end
         end
         ST_SWEEP: begin
            cur_in = ptr_ff;
            if (!allowed) begin
               we = 1'b1;
               wa = cur_ff[AW-1:0];
            end
            ptr_in = ptr_ff + 1'b1;
            if (cur_ff == LAST) st_in = ST_DONE;
         end
         ST_DONE: begin
            rv_in = 1'b1;
            rsp_in.range_low = 8'(lo_ff);
            rsp_in.range_high = 8'(hi_ff);
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLEAR;
         ptr_ff <= '0;
         cur_ff <= '0;
         lo_ff <= '0;
         hi_ff <= AW'(NUM_SYMBOLS - 1);
         vld_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ptr_ff <= (st_ff == ST_IDLE && st_in == ST_SWEEP) ? (AW+1)'(1) : ptr_in;
         cur_ff <= (st_ff == ST_IDLE && st_in == ST_SWEEP) ? '0 : cur_in;
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         vld_ff <= vld_in;
         rv_ff <= rv_in;
      end
      best_ff <= best_in;
      num_ff <= num_in;
      den_ff <= den_in;
      max_ff <= max_in;
      rsp_ff <= rsp_in;
   end
endmodule
